// ===== rtl/tle_pkg.sv =====
package tle_pkg;

  localparam int LINE_CAP    = 64;
  localparam int STORE_DEPTH = 63;
  localparam int CAPACITY    = (LINE_CAP - 1 > STORE_DEPTH) ? STORE_DEPTH : LINE_CAP - 1;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

  // echo sequences are sent only when shorter than the line capacity
  localparam int  ECHO_LF_N = (LINE_CAP > 2) ? 2 : 0;
  localparam bit  BS_ECHO   = (LINE_CAP > 3);

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_DEL = 8'h7F;
  localparam logic [7:0] CHAR_SP  = 8'h20;

  localparam int          PADDR_W     = 3;
  localparam logic [0:0]  REG_ENABLED = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_BS,
    S_LF_RD,
    S_LF_OUT
  } tle_state_e;

  typedef struct packed {
    logic             we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } tle_ram_req_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       line_valid;
    logic [7:0] line_byte;
    logic       line_end;
    logic       last;
  } tle_result_t;

endpackage

// ===== rtl/tle_line_ram.sv =====
module tle_line_ram (
  input  logic                 clk_i,
  input  tle_pkg::tle_ram_req_t req_i,
  output logic [7:0]           rdata_o
);
  import tle_pkg::*;

  logic [7:0] mem_q [STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tle_ctrl.sv =====
module tle_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  enabled_i,
  input  logic                  s_valid_i,
  output logic                  s_ready_o,
  input  logic [7:0]            rx_byte_i,
  input  logic                  m_ready_i,
  output logic                  m_valid_o,
  output tle_pkg::tle_result_t  result_o,
  output tle_pkg::tle_ram_req_t ram_req_o,
  input  logic [7:0]            ram_rdata_i
);
  import tle_pkg::*;

  tle_state_e  state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] k_q, k_d;
  logic [LEN_W-1:0] n_q, n_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [7:0]  byte_q;
  logic        out_valid_q, out_valid_d;
  tle_result_t res_q, res_d;

  logic accept, emit_ok, load, lf_fin;
  logic is_drop, is_lf, is_bs, can_append;
  logic [LEN_W-1:0] n_lf;

  assign accept     = s_valid_i && s_ready_o;
  assign emit_ok    = !out_valid_q || m_ready_i;
  assign is_drop    = !enabled_i || (rx_byte_i == CHAR_CR);
  assign is_lf      = rx_byte_i == CHAR_LF;
  assign is_bs      = (rx_byte_i == CHAR_BS) || (rx_byte_i == CHAR_DEL);
  assign can_append = len_q < LEN_W'(CAPACITY);
  assign lf_fin     = k_q == (n_q - LEN_W'(1));

  always_comb begin
    n_lf = (len_q > LEN_W'(ECHO_LF_N)) ? len_q : LEN_W'(ECHO_LF_N);
    if (n_lf == '0) begin
      n_lf = LEN_W'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (is_drop) begin
            state_d = S_IDLE;
          end else if (is_lf) begin
            state_d = S_LF_RD;
          end else if (is_bs) begin
            if (len_q != '0 && BS_ECHO) state_d = S_BS;
          end else if (can_append) begin
            state_d = S_ECHO;
          end else begin
            // line full, byte dropped
            state_d = S_IDLE;
          end
        end
      end
      S_ECHO: begin
        if (emit_ok) state_d = S_IDLE;
      end
      S_BS: begin
        if (emit_ok && cnt_q == 2'd2) state_d = S_IDLE;
      end
      S_LF_RD: begin
        state_d = S_LF_OUT;
      end
      S_LF_OUT: begin
        if (emit_ok) state_d = lf_fin ? S_IDLE : S_LF_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_ready_o       = state_q == S_IDLE;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = len_q[ADDR_W-1:0];
    ram_req_o.wdata = rx_byte_i;
    ram_req_o.raddr = k_q[ADDR_W-1:0];
    load            = 1'b0;
    res_d           = '0;
    unique case (state_q)
      S_IDLE: begin
        ram_req_o.we = accept && !is_drop && !is_lf && !is_bs && can_append;
      end
      S_ECHO: begin
        load             = emit_ok;
        res_d.echo_valid = 1'b1;
        res_d.echo_byte  = byte_q;
        res_d.last       = 1'b1;
      end
      S_BS: begin
        load             = emit_ok;
        res_d.echo_valid = 1'b1;
        res_d.echo_byte  = (cnt_q == 2'd1) ? CHAR_SP : CHAR_BS;
        res_d.last       = cnt_q == 2'd2;
      end
      S_LF_RD: begin
        load = 1'b0;
      end
      S_LF_OUT: begin
        load             = emit_ok;
        res_d.echo_valid = k_q < LEN_W'(ECHO_LF_N);
        if (res_d.echo_valid) begin
          res_d.echo_byte = (k_q == '0) ? CHAR_CR : CHAR_LF;
        end
        res_d.line_valid = k_q < len_q;
        if (res_d.line_valid) begin
          res_d.line_byte = ram_rdata_i;
        end
        res_d.line_end   = lf_fin;
        res_d.last       = lf_fin;
      end
      default: load = 1'b0;
    endcase
  end

  always_comb begin
    len_d       = len_q;
    k_d         = k_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    out_valid_d = load ? 1'b1 : (out_valid_q && !m_ready_i);
    if (accept && !is_drop) begin
      if (is_lf) begin
        k_d = '0;
        n_d = n_lf;
      end else if (is_bs) begin
        if (len_q != '0) len_d = len_q - LEN_W'(1);
        cnt_d = '0;
      end else if (can_append) begin
        len_d = len_q + LEN_W'(1);
      end
    end
    if (load && state_q == S_BS) begin
      cnt_d = cnt_q + 2'd1;
    end
    if (load && state_q == S_LF_OUT) begin
      k_d = k_q + LEN_W'(1);
      if (lf_fin) len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      k_q         <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      k_q         <= k_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) byte_q <= rx_byte_i;
    if (load) res_q <= res_d;
  end

  assign m_valid_o = out_valid_q;
  assign result_o  = res_q;

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAPACITY))
    else $error("line length above capacity");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LF_OUT |-> k_q < n_q)
    else $error("line walk index out of range");

  a_lf_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && state_q == S_LF_OUT && lf_fin) |=> len_q == '0)
    else $error("line not cleared after line feed");

  a_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> (accept && state_q == S_IDLE && can_append))
    else $error("line store written outside an accepted append");

endmodule

// ===== rtl/terminal_line_editor.sv =====
// Terminal line editor: takes received bytes on the slave stream and returns echo and line
// results on the master stream, one word per result, tlast on the final word of each byte.
// Carriage return and any byte taken while disabled give no word; a stored character gives
// one word, backspace or DEL three (none on an empty line). A line feed gives
// max(2, length, 1) words: echo fields carry CR and LF on the first two, line fields carry
// the stored line in order, and line_end is set on the final one. Input is taken one byte
// at a time, only in the idle state. A line feed reads the single line RAM, which has a
// registered read, once per word, through a read state and then an output state. Each word
// can wait longer while the receiver holds off. A finished word waits in the output
// register while the next byte is taken. The enabled register is selected when paddr bit 2
// is 0 (APB addresses 0 to 3) and resets to 0.
module terminal_line_editor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tle_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // echo_valid, echo_byte, line_valid, line_byte, line_end, zero fill
  output logic [23:0]                 m_axis_tdata,
  output logic                        m_axis_tlast   // last
);
  import tle_pkg::*;

  logic         enabled_q;
  logic         reg_sel;
  tle_ram_req_t ram_req;
  logic [7:0]   ram_rdata;
  tle_result_t  result;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1 -: 1] == REG_ENABLED;
  assign prdata  = reg_sel ? {31'b0, enabled_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      enabled_q <= pwdata[0];
    end
  end

  tle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enabled_i   (enabled_q),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .rx_byte_i   (s_axis_tdata),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .result_o    (result),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  tle_line_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata = {5'b0, result.line_end, result.line_byte, result.line_valid,
                         result.echo_byte, result.echo_valid};
  assign m_axis_tlast = result.last;

endmodule
